@@ rtl/spq_pkg.sv @@
// Package: sizes, op codes and shared types for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int DEPTH          = 16;
	localparam int ITEM_WIDTH     = 32;
	localparam int PRIORITY_WIDTH = 16;
	localparam int OP_WIDTH       = 2;
	localparam int COUNT_WIDTH    = 5;
	localparam int OCC_WIDTH      = $clog2(DEPTH + 1);

	localparam logic [OP_WIDTH-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_DEQ  = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_PEEK = 2'd2;

	typedef logic [OCC_WIDTH-1:0] occ_t;

	typedef struct packed {
		logic                             vld;
		logic [ITEM_WIDTH-1:0]            value;
		logic signed [PRIORITY_WIDTH-1:0] prio;
	} slot_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_cmd_t;

endpackage

@@ rtl/spq_if.sv @@
// Interfaces: request and result channels of the sorted priority queue.
`timescale 1ns / 1ps
interface spq_in_if import spq_pkg::*; ();
	logic                             valid;
	logic                             ready;
	logic [OP_WIDTH-1:0]              op;
	logic [ITEM_WIDTH-1:0]            item_value;
	logic signed [PRIORITY_WIDTH-1:0] item_priority;

	modport source (output valid, output op, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input op, input item_value, input item_priority,
		output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
	logic                             valid;
	logic                             ready;
	logic [ITEM_WIDTH-1:0]            front_value;
	logic signed [PRIORITY_WIDTH-1:0] front_priority;
	logic [COUNT_WIDTH-1:0]           entry_count;
	logic                             is_empty;
	logic                             refused;

	modport source (output valid, output front_value, output front_priority,
		output entry_count, output is_empty, output refused, input ready);
	modport sink (input valid, input front_value, input front_priority,
		input entry_count, input is_empty, input refused, output ready);
endinterface

@@ rtl/sorted_priority_queue.sv @@
// Top level: sorted priority queue built as a row of slot cells with a result register.
// Results: an accepted request's result is registered and shown in the cycle after it is taken.
// Throughput: one request per cycle; every cell updates in parallel from its neighbors.
// The input stalls only while a finished result waits on a stalled output.
// Reset: occupancy and all slot valid bits clear, result register empties.
`timescale 1ns / 1ps
module sorted_priority_queue import spq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	spq_in_if.sink           req,
	spq_out_if.source        rsp
);

	// Count of held entries; slot i is valid exactly when i < occ_q.
	occ_t      occ_q;
	occ_t      occ_nxt;
	logic      take;
	logic      is_full;
	logic      is_none;
	logic      enq_ok;
	logic      deq_ok;
	logic      refuse;
	cell_cmd_t cmd;
	slot_t     new_slot;

	slot_t     cur  [DEPTH];
	slot_t     nxt  [DEPTH];
	logic      keep [DEPTH];

	// Result register.
	logic                             rsp_vld_q;
	logic [ITEM_WIDTH-1:0]            front_value_q;
	logic signed [PRIORITY_WIDTH-1:0] front_priority_q;
	logic [COUNT_WIDTH-1:0]           entry_count_q;
	logic                             is_empty_q;
	logic                             refused_q;

	// Take a new request whenever the result slot is free or drains this cycle.
	assign req.ready = !rsp_vld_q || rsp.ready;
	assign take      = req.valid && req.ready;

	assign is_full = (occ_q == occ_t'(DEPTH));
	assign is_none = (occ_q == '0);

	always_comb begin
		enq_ok = 1'b0;
		deq_ok = 1'b0;
		refuse = 1'b0;
		case (req.op)
			OP_ENQ: begin
				enq_ok = !is_full;
				refuse = is_full;
			end
			OP_DEQ: begin
				deq_ok = !is_none;
				refuse = is_none;
			end
			OP_PEEK: begin
				enq_ok = 1'b0;
			end
			default: begin
				// unused code acts as peek
				enq_ok = 1'b0;
			end
		endcase
	end

	assign cmd.enq = take && enq_ok;
	assign cmd.deq = take && deq_ok;

	assign new_slot = '{vld: 1'b1, value: req.item_value, prio: req.item_priority};

	always_comb begin
		occ_nxt = occ_q;
		if (cmd.enq) begin
			occ_nxt = occ_q + occ_t'(1);
		end else if (cmd.deq) begin
			occ_nxt = occ_q - occ_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_nxt;
		end
	end

	// Cell row: cell 0 is the front. Each cell sees its left neighbor's keep
	// decision; the front cell treats its missing left neighbor as kept, so an
	// insert that passes it lands there.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slot_t left_slot;
		slot_t right_slot;
		logic  left_keep;

		if (i == 0) begin : g_first
			assign left_slot = '0;
			assign left_keep = 1'b1;
		end else begin : g_mid
			assign left_slot = cur[i-1];
			assign left_keep = keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_slot = '0;
		end else begin : g_inner
			assign right_slot = cur[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_slot  (new_slot),
			.left      (left_slot),
			.left_keep (left_keep),
			.right     (right_slot),
			.cur       (cur[i]),
			.keep      (keep[i]),
			.nxt       (nxt[i])
		);
	end

	// Result register: describes the queue after the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (take) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			front_value_q    <= nxt[0].vld ? nxt[0].value : '0;
			front_priority_q <= nxt[0].vld ? nxt[0].prio : '0;
			entry_count_q    <= COUNT_WIDTH'(occ_nxt);
			is_empty_q       <= (occ_nxt == '0);
			refused_q        <= refuse;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.front_value    = front_value_q;
	assign rsp.front_priority = front_priority_q;
	assign rsp.entry_count    = entry_count_q;
	assign rsp.is_empty       = is_empty_q;
	assign rsp.refused        = refused_q;

endmodule

@@ rtl/spq_cell.sv @@
// One slot of the sorted chain: holds, shifts right on insert, shifts left on removal.
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  slot_t     new_slot,
	input  slot_t     left,
	input  logic      left_keep,
	input  slot_t     right,
	output slot_t     cur,
	output logic      keep,
	output slot_t     nxt
);

	logic                             vld_q;
	logic [ITEM_WIDTH-1:0]            value_q;
	logic signed [PRIORITY_WIDTH-1:0] prio_q;

	assign cur = '{vld: vld_q, value: value_q, prio: prio_q};

	// ties stay ahead of the newcomer
	assign keep = vld_q && ($signed(new_slot.prio) >= $signed(prio_q));

	always_comb begin
		nxt = cur;
		if (cmd.enq) begin
			if (keep) begin
				nxt = cur;
			end else if (left_keep) begin
				nxt = new_slot;
			end else begin
				nxt = left;
			end
		end else if (cmd.deq) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt.value;
		prio_q  <= nxt.prio;
	end

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
// Testbench: sorted priority queue checked request by request against a shadow sorted list.
`timescale 1ns / 1ps
module sorted_priority_queue_tb;
	import spq_pkg::*;

	// op code 3 has no name in the package; the block treats it as a peek
	localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1850;
	localparam int IDLE_LIMIT      = 2000;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic [ITEM_WIDTH-1:0]            front_value;
		logic signed [PRIORITY_WIDTH-1:0] front_priority;
		logic [COUNT_WIDTH-1:0]           entry_count;
		logic                             is_empty;
		logic                             refused;
	} front_t;

	typedef struct packed {
		logic [OP_WIDTH-1:0]              op;
		logic [ITEM_WIDTH-1:0]            value;
		logic signed [PRIORITY_WIDTH-1:0] prio;
		logic                             typed;
		front_t                           want;
	} directed_row_t;

	typedef enum int {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_MIX} traffic_mode_e;
	typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_LONG} stall_mode_e;

	logic clk;
	logic arst_n;

	spq_in_if  req_ch ();
	spq_out_if rsp_ch ();

	sorted_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the sorted slots, front at index 0
	logic [ITEM_WIDTH-1:0]            shadow_value [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] shadow_prio  [DEPTH];
	int                               shadow_count;

	front_t        expected_fronts [$];
	directed_row_t directed_rows [$];

	int mismatch_count;
	int reported_count;
	int idle_cycles;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the shadow list and return the front summary after it.
	function automatic front_t queue_after(input logic [OP_WIDTH-1:0] op,
		input logic [ITEM_WIDTH-1:0] value, input logic signed [PRIORITY_WIDTH-1:0] prio);
		front_t r;
		int     pos;
		int     i;
		logic   turned_away;
		turned_away = 1'b0;
		if (op == OP_ENQ) begin
			if (shadow_count >= DEPTH) begin
				turned_away = 1'b1;
			end else begin
				// equal priority goes behind what is already queued
				pos = 0;
				while (pos < shadow_count && prio >= shadow_prio[pos])
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_value[i] = shadow_value[i-1];
					shadow_prio[i]  = shadow_prio[i-1];
				end
				shadow_value[pos] = value;
				shadow_prio[pos]  = prio;
				shadow_count++;
			end
		end else if (op == OP_DEQ) begin
			if (shadow_count == 0) begin
				turned_away = 1'b1;
			end else begin
				for (i = 0; i + 1 < shadow_count; i++) begin
					shadow_value[i] = shadow_value[i+1];
					shadow_prio[i]  = shadow_prio[i+1];
				end
				shadow_count--;
			end
		end
		r.front_value    = (shadow_count > 0) ? shadow_value[0] : '0;
		r.front_priority = (shadow_count > 0) ? shadow_prio[0] : '0;
		r.entry_count    = COUNT_WIDTH'(shadow_count);
		r.is_empty       = (shadow_count == 0);
		r.refused        = turned_away;
		return r;
	endfunction

	// Often a handful of close priorities so ties are common, some extremes, rest anything.
	function automatic logic signed [PRIORITY_WIDTH-1:0] pick_priority();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return PRIORITY_WIDTH'($signed($urandom_range(0, 4)) - 2);
		if (r < 55) begin
			case ($urandom_range(0, 3))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				2: return -16'sd1;
				default: return 16'sd0;
			endcase
		end
		return PRIORITY_WIDTH'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input front_t want, input front_t got);
		mismatch_count++;
		if (reported_count < MAX_REPORTS) begin
			reported_count++;
			$display("%0t mismatch (%s): want val=%h pri=%0d cnt=%0d emp=%b ref=%b", $time, what,
				want.front_value, want.front_priority, want.entry_count, want.is_empty,
				want.refused);
			$display("%0t              got  val=%h pri=%0d cnt=%0d emp=%b ref=%b", $time,
				got.front_value, got.front_priority, got.entry_count, got.is_empty, got.refused);
		end
	endtask

	// Bursts of back-to-back requests separated by random gaps; called at a rising edge.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Present one request, hold it until taken, then log what the queue should report.
	// Returns at the accepting rising edge.
	task automatic drive_request(input logic [OP_WIDTH-1:0] op, input logic [ITEM_WIDTH-1:0] value,
		input logic signed [PRIORITY_WIDTH-1:0] prio, input logic typed, input front_t want);
		front_t predicted;
		pace_sender();
		req_ch.valid         <= 1'b1;
		req_ch.op            <= op;
		req_ch.item_value    <= value;
		req_ch.item_priority <= prio;
		// handshake sampled mid-cycle where everything is settled
		do
			@(negedge clk);
		while (!req_ch.ready);
		predicted = queue_after(op, value, prio);
		expected_fronts.push_back(typed ? want : predicted);
		@(posedge clk);
	endtask

	// Wait with the input quiet until every outstanding result has drained.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_fronts.size() != 0);
	endtask

	// Receiver: its own stall pattern, in segments.
	initial begin
		stall_mode_e mode;
		int          len;
		int          k;
		rsp_ch.ready <= 1'b0;
		forever begin
			mode = stall_mode_e'($urandom_range(0, 3));
			len  = $urandom_range(5, 60);
			for (k = 0; k < len; k++) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:   rsp_ch.ready <= 1'b1;
					STALL_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					STALL_SPARSE: rsp_ch.ready <= (k % 4 == 3);
					STALL_LONG:   rsp_ch.ready <= (k >= 30);
					default:      rsp_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Result checker and idle counter, both sampled at the falling edge.
	always @(negedge clk) begin : result_check
		front_t got;
		front_t want;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.front_value, rsp_ch.front_priority, rsp_ch.entry_count,
					rsp_ch.is_empty, rsp_ch.refused};
				if (expected_fronts.size() == 0) begin
					report_mismatch("no request pending", '0, got);
				end else begin
					want = expected_fronts.pop_front();
					if (got.front_value !== want.front_value ||
						got.front_priority !== want.front_priority ||
						got.entry_count !== want.entry_count ||
						got.is_empty !== want.is_empty ||
						got.refused !== want.refused)
						report_mismatch("field", want, got);
				end
			end
		end
	end

	// Watchdog: too long with nothing moving on either channel.
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int            n;
		int            sent;
		int            len;
		int            r;
		traffic_mode_e mode;
		logic [OP_WIDTH-1:0]              op;
		logic [ITEM_WIDTH-1:0]            value;
		logic signed [PRIORITY_WIDTH-1:0] prio;
		bit            first_segment;

		mismatch_count = 0;
		reported_count = 0;
		idle_cycles    = 0;
		burst_left     = 0;
		shadow_count   = 0;
		for (n = 0; n < DEPTH; n++) begin
			shadow_value[n] = '0;
			shadow_prio[n]  = '0;
		end

		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.op            <= OP_PEEK;
		req_ch.item_value    <= '0;
		req_ch.item_priority <= '0;

		// directed requests; typed rows carry a result that is obvious by inspection
		directed_rows.push_back('{OP_PEEK, 32'h0, 16'sd0, 1'b1,
			'{32'h0, 16'sd0, 5'd0, 1'b1, 1'b0}});              // fresh out of reset
		directed_rows.push_back('{OP_DEQ, 32'hffffffff, 16'sh7fff, 1'b1,
			'{32'h0, 16'sd0, 5'd0, 1'b1, 1'b1}});              // dequeue when empty
		directed_rows.push_back('{OP_ENQ, 32'hffffffff, 16'sh7fff, 1'b1,
			'{32'hffffffff, 16'sh7fff, 5'd1, 1'b0, 1'b0}});
		directed_rows.push_back('{OP_ENQ, 32'h0, 16'sh8000, 1'b1,
			'{32'h0, 16'sh8000, 5'd2, 1'b0, 1'b0}});
		directed_rows.push_back('{OP_ENQ, 32'h5, 16'sh8000, 1'b1,
			'{32'h0, 16'sh8000, 5'd3, 1'b0, 1'b0}});           // tie queues behind
		directed_rows.push_back('{OP_UNUSED, 32'h0, 16'sd0, 1'b1,
			'{32'h0, 16'sh8000, 5'd3, 1'b0, 1'b0}});           // unused code peeks
		directed_rows.push_back('{OP_DEQ, 32'h0, 16'sd0, 1'b1,
			'{32'h5, 16'sh8000, 5'd2, 1'b0, 1'b0}});
		directed_rows.push_back('{OP_ENQ, 32'ha5a5a5a5, 16'sd7, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h5a5a5a5a, -16'sd1, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h00000001, 16'sd0, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h00000002, 16'sd7, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h80000000, 16'sd100, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h7fffffff, -16'sd100, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h00000003, 16'sd7, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'hdeadbeef, 16'sh7fff, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h0000ffff, 16'sd1, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'hffff0000, -16'sd32767, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h12121212, 16'sd0, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h34343434, 16'sd42, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h00000004, 16'sd7, 1'b0, '0});
		directed_rows.push_back('{OP_ENQ, 32'h56565656, 16'sd3, 1'b0, '0});    // now full
		directed_rows.push_back('{OP_ENQ, 32'h12345678, -16'sd5, 1'b1,
			'{32'h5, 16'sh8000, 5'd16, 1'b0, 1'b1}});          // enqueue when full
		directed_rows.push_back('{OP_PEEK, 32'h0, 16'sd0, 1'b0, '0});
		directed_rows.push_back('{OP_DEQ, 32'h0, 16'sd0, 1'b0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
				directed_rows[i].typed, directed_rows[i].want);

		// random traffic in segments that push the queue toward full, toward empty, or hold it
		sent = 0;
		first_segment = 1'b1;
		while (sent < RANDOM_REQUESTS) begin
			mode = traffic_mode_e'($urandom_range(0, 2));
			len  = $urandom_range(40, 120);
			if (first_segment || $urandom_range(0, 4) == 0) begin
				drain_results();
				burst_left = 0;
			end
			first_segment = 1'b0;
			for (n = 0; n < len; n++) begin
				r = $urandom_range(0, 99);
				case (mode)
					TRAFFIC_FILL:  op = (r < 80) ? OP_ENQ : (r < 92) ? OP_DEQ :
						(r < 97) ? OP_PEEK : OP_UNUSED;
					TRAFFIC_DRAIN: op = (r < 15) ? OP_ENQ : (r < 90) ? OP_DEQ :
						(r < 96) ? OP_PEEK : OP_UNUSED;
					default:       op = (r < 45) ? OP_ENQ : (r < 85) ? OP_DEQ :
						(r < 95) ? OP_PEEK : OP_UNUSED;
				endcase
				case ($urandom_range(0, 9))
					0:       value = '0;
					1:       value = '1;
					default: value = $urandom;
				endcase
				prio = pick_priority();
				drive_request(op, value, prio, 1'b0, '0);
				sent++;
			end
		end

		// wind down: let the last results out, then idle before the final report
		drain_results();
		repeat (8) @(posedge clk);
		mismatch_count += expected_fronts.size();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
